// ===== src/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator package
// Shared sizes, status codes, state encodings and the memory control structs.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int NumBlocks  = 2048;
    localparam int BlockBytes = 4096;
    localparam int BlkW       = $clog2(NumBlocks);        // block index width
    localparam int CntW       = BlkW + 1;                 // count up to NumBlocks
    localparam int OffW       = $clog2(BlockBytes);
    localparam int WordBits   = 32;
    localparam int BitW       = $clog2(WordBits);
    localparam int NumWords   = NumBlocks / WordBits;
    localparam int WordW      = $clog2(NumWords);
    localparam logic [31:0] HeaderBytes = 32'd4;

    typedef enum logic [3:0] {
        ST_ALLOC_OK  = 4'd0,
        ST_FREE_OK   = 4'd1,
        ST_ZERO      = 4'd2,
        ST_TOO_LARGE = 4'd3,
        ST_NO_ROOM   = 4'd4,
        ST_NULL      = 4'd5,
        ST_BEFORE    = 4'd6,
        ST_BEYOND    = 4'd7,
        ST_BAD_COUNT = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_LEN_RD,
        S_LEN_CHK,
        S_DONE
    } t_state;

    // Bitmap memory port: one word read or one word written per cycle.
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [WordW-1:0] addr;
        logic [WordBits-1:0] wdata;
    } t_map_req;

    // Length memory port.
    typedef struct packed {
        logic            rd;
        logic            wr;
        logic [BlkW-1:0] addr;
        logic [CntW-1:0] wdata;
    } t_len_req;

endpackage

// ===== src/bitmap_first_fit_block_allocator.sv =====
// Allocate passes each bitmap word that is all used, or all free and short of the run,
// as a whole and any other of the 64 words bit by bit; marking reads and rewrites
// each word marked. Free reads and checks the stored run length, then clears likewise.
// One request at a time; busy stays high until the result strobe.
// After reset a clearing pass sweeps both memories while busy is high.
// The result is shown for one cycle on o_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator
// Sequencer that scans, marks and clears a bitmap held in word memory.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_opcode,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_free_address,
    output logic        o_valid,
    output logic [31:0] o_result_address,
    output logic [3:0]  o_status,
    output logic [11:0] o_used_blocks
);
    localparam int BlkW = bffa_pkg::BlkW;
    localparam int CntW = bffa_pkg::CntW;
    localparam int OffW = bffa_pkg::OffW;
    localparam int BitW = bffa_pkg::BitW;
    localparam int WordW = bffa_pkg::WordW;
    localparam int WordBits = bffa_pkg::WordBits;

    bffa_pkg::t_state r_state, n_state;
    logic [31:0]      r_kend;
    logic [CntW-1:0]  r_used, n_used;
    logic             r_clr, n_clr;
    logic [BlkW-1:0]  r_clr_idx, n_clr_idx;
    logic [CntW-1:0]  r_need, n_need;       // blocks wanted / run length
    logic [CntW-1:0]  r_run, n_run;         // free run length so far
    logic [BlkW-1:0]  r_start, n_start;     // run start block
    logic [CntW-1:0]  r_pos, n_pos;         // current block index (may reach NumBlocks)
    logic [CntW-1:0]  r_left, n_left;       // bits left to mark/clear
    logic             r_set, n_set;         // mark (1) or clear (0)
    logic [31:0]      r_addr, n_addr;
    logic [3:0]       r_stat, n_stat;
    logic             r_out, n_out;
    logic [WordBits-1:0] map_rdata;
    logic [CntW-1:0]  len_rdata;
    bffa_pkg::t_map_req map_req;
    bffa_pkg::t_len_req len_req;

    bffa_map_ram u_map (.i_clk(i_clk), .i_req(map_req), .o_rdata(map_rdata));
    bffa_len_ram u_len (.i_clk(i_clk), .i_req(len_req), .o_rdata(len_rdata));

    // Heap base: kernel_end rounded up to a block, modulo 2^32.
    logic [32:0] base_sum;
    logic [31:0] base;
    assign base_sum = {1'b0, r_kend} + 33'(bffa_pkg::BlockBytes - 1);
    assign base = {base_sum[31:OffW], OffW'(0)};

    // Request decode.
    logic [32:0] total;
    logic [32-OffW:0] blocks;
    logic [31:0] hdr, hoff;
    assign total  = {1'b0, i_request_bytes} + 33'(bffa_pkg::HeaderBytes)
                    + 33'(bffa_pkg::BlockBytes - 1);
    assign blocks = total[32:OffW];
    assign hdr    = i_free_address - bffa_pkg::HeaderBytes;
    assign hoff   = hdr - base;

    // Scan within one word: words all used, or all free and short of the run, pass at
    // once; any other word is scanned one bit per cycle.
    logic [BitW-1:0] bit_sel;
    logic [WordW-1:0] word_sel;
    assign bit_sel  = r_pos[BitW-1:0];
    assign word_sel = r_pos[BlkW-1:BitW];
    logic [WordBits-1:0] r_word, n_word;

    assign busy        = (r_state != bffa_pkg::S_IDLE) || r_clr;
    assign o_cfg_ready = 1'b1;
    assign o_valid          = r_out;
    assign o_result_address = r_addr;
    assign o_status         = r_stat;
    assign o_used_blocks    = r_used[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bffa_pkg::S_IDLE;
            r_kend    <= '0;
            r_used    <= '0;
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_out     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_clr     <= n_clr;
            r_clr_idx <= n_clr_idx;
            r_out     <= n_out;
            if (i_cfg_valid && o_cfg_ready) begin
                r_kend <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need  <= n_need;
        r_run   <= n_run;
        r_start <= n_start;
        r_pos   <= n_pos;
        r_left  <= n_left;
        r_set   <= n_set;
        r_addr  <= n_addr;
        r_stat  <= n_stat;
        r_word  <= n_word;
    end

    always_comb begin
        n_state = r_state;
        n_used = r_used;
        n_clr = r_clr;
        n_clr_idx = r_clr_idx;
        n_need = r_need;
        n_run = r_run;
        n_start = r_start;
        n_pos = r_pos;
        n_left = r_left;
        n_set = r_set;
        n_addr = r_addr;
        n_stat = r_stat;
        n_word = r_word;
        n_out = 1'b0;
        map_req = '0;
        len_req = '0;

        if (r_clr) begin
            // Clearing pass: one length entry per cycle, bitmap words alongside.
            len_req.wr = 1'b1;
            len_req.addr = r_clr_idx;
            map_req.wr = 1'b1;
            map_req.addr = r_clr_idx[WordW-1:0];
            n_clr_idx = r_clr_idx + 1'b1;
            if (r_clr_idx == BlkW'(bffa_pkg::NumBlocks - 1)) begin
                n_clr = 1'b0;
            end
        end else begin
            case (r_state)
                bffa_pkg::S_IDLE: begin
                    if (start) begin
                        n_addr = '0;
                        if (!i_opcode) begin
                            if (i_request_bytes == 32'd0) begin
                                n_stat = bffa_pkg::ST_ZERO;
                                n_state = bffa_pkg::S_DONE;
                            end else if (blocks > (33-OffW)'(bffa_pkg::NumBlocks)) begin
                                n_stat = bffa_pkg::ST_TOO_LARGE;
                                n_state = bffa_pkg::S_DONE;
                            end else begin
                                n_need = CntW'(blocks);
                                n_run = '0;
                                n_pos = '0;
                                n_state = bffa_pkg::S_SCAN_RD;
                            end
                        end else begin
                            if (i_free_address == 32'd0) begin
                                n_stat = bffa_pkg::ST_NULL;
                                n_state = bffa_pkg::S_DONE;
                            end else if (hdr < base) begin
                                n_stat = bffa_pkg::ST_BEFORE;
                                n_state = bffa_pkg::S_DONE;
                            end else if (hoff[31:OffW] >= (32-OffW)'(bffa_pkg::NumBlocks)) begin
                                n_stat = bffa_pkg::ST_BEYOND;
                                n_state = bffa_pkg::S_DONE;
                            end else begin
                                n_start = hoff[OffW+BlkW-1:OffW];
                                len_req.rd = 1'b1;
                                len_req.addr = hoff[OffW+BlkW-1:OffW];
                                n_state = bffa_pkg::S_LEN_RD;
                            end
                        end
                    end
                end
                bffa_pkg::S_SCAN_RD: begin
                    if (r_pos == CntW'(bffa_pkg::NumBlocks)) begin
                        n_stat = bffa_pkg::ST_NO_ROOM;
                        n_state = bffa_pkg::S_DONE;
                    end else begin
                        map_req.rd = 1'b1;
                        map_req.addr = word_sel;
                        n_state = bffa_pkg::S_SCAN;
                    end
                end
                bffa_pkg::S_SCAN: begin
                    // Whole free word extends the run at once when it cannot finish it.
                    if (map_rdata == '0 && (r_run + CntW'(WordBits)) < r_need) begin
                        n_run = r_run + CntW'(WordBits);
                        n_pos = r_pos + CntW'(WordBits);
                        n_state = bffa_pkg::S_SCAN_RD;
                    end else if (map_rdata == '1) begin
                        n_run = '0;
                        n_pos = r_pos + CntW'(WordBits);
                        n_state = bffa_pkg::S_SCAN_RD;
                    end else begin
                        // One bit per cycle; the read data stays on the port.
                        if (map_rdata[bit_sel]) begin
                            n_run = '0;
                        end else begin
                            n_run = r_run + 1'b1;
                        end
                        n_pos = r_pos + 1'b1;
                        if (!map_rdata[bit_sel] && (r_run + 1'b1) == r_need) begin
                            n_start = BlkW'(r_pos + 1'b1 - r_need);
                            n_pos = (r_pos + 1'b1 - r_need);
                            n_left = r_need;
                            n_set = 1'b1;
                            n_state = bffa_pkg::S_MARK_RD;
                        end else if (bit_sel == BitW'(WordBits - 1)) begin
                            n_state = bffa_pkg::S_SCAN_RD;
                        end
                    end
                end
                bffa_pkg::S_MARK_RD: begin
                    if (r_left == '0 || r_pos == CntW'(bffa_pkg::NumBlocks)) begin
                        if (r_set) begin
                            len_req.wr = 1'b1;
                            len_req.addr = r_start;
                            len_req.wdata = r_need;
                            n_used = r_used + r_need;
                            n_addr = base + {r_start, OffW'(0)} + bffa_pkg::HeaderBytes;
                            n_stat = bffa_pkg::ST_ALLOC_OK;
                        end else begin
                            n_used = (r_used > r_need) ? r_used - r_need : '0;
                            n_stat = bffa_pkg::ST_FREE_OK;
                        end
                        n_state = bffa_pkg::S_DONE;
                    end else begin
                        map_req.rd = 1'b1;
                        map_req.addr = word_sel;
                        n_state = bffa_pkg::S_MARK_WR;
                    end
                end
                bffa_pkg::S_MARK_WR: begin
                    // Set or clear the run's bits inside this word, all in a single write.
                    n_word = map_rdata;
                    for (int k = 0; k < WordBits; k++) begin
                        if (BitW'(k) >= bit_sel
                            && CntW'(k) < CntW'(bit_sel) + r_left) begin
                            n_word[k] = r_set;
                        end
                    end
                    map_req.wr = 1'b1;
                    map_req.addr = word_sel;
                    map_req.wdata = n_word;
                    if (r_left > CntW'(WordBits) - CntW'(bit_sel)) begin
                        n_left = r_left - (CntW'(WordBits) - CntW'(bit_sel));
                        n_pos = {r_pos[CntW-1:BitW] + 1'b1, BitW'(0)};
                    end else begin
                        n_left = '0;
                    end
                    n_state = bffa_pkg::S_MARK_RD;
                end
                bffa_pkg::S_LEN_RD: begin
                    n_state = bffa_pkg::S_LEN_CHK;
                end
                bffa_pkg::S_LEN_CHK: begin
                    if (len_rdata == '0 || len_rdata > CntW'(bffa_pkg::NumBlocks)) begin
                        n_stat = bffa_pkg::ST_BAD_COUNT;
                        n_state = bffa_pkg::S_DONE;
                    end else begin
                        n_need = len_rdata;
                        n_left = len_rdata;
                        n_pos = {1'b0, r_start};
                        n_set = 1'b0;
                        n_state = bffa_pkg::S_MARK_RD;
                    end
                end
                bffa_pkg::S_DONE: begin
                    n_out = 1'b1;
                    n_state = bffa_pkg::S_IDLE;
                end
                default: begin
                    n_state = bffa_pkg::S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_valid_ok_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bffa_pkg::ST_ALLOC_OK |-> o_result_address == 32'd0)
        else $error("nonzero address on a failed or free result");
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CntW'(bffa_pkg::NumBlocks))
        else $error("used count exceeds heap size");
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bffa_pkg::S_DONE |=> o_valid)
        else $error("missing result strobe");
    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> r_state == bffa_pkg::S_IDLE)
        else $error("request taken during clearing pass");
`endif
endmodule

// ===== src/bffa_map_ram.sv =====
// ----------------------------------------------------------------------------
// Bitmap word memory
// Used/free bits in 32-bit words, registered read, swept clear after reset.
// ----------------------------------------------------------------------------
module bffa_map_ram (
    input  logic                          i_clk,
    input  bffa_pkg::t_map_req            i_req,
    output logic [bffa_pkg::WordBits-1:0] o_rdata
);
    logic [bffa_pkg::WordBits-1:0] r_mem [bffa_pkg::NumWords];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            o_rdata <= r_mem[i_req.addr];
        end
    end
endmodule

// ===== src/bffa_len_ram.sv =====
// ----------------------------------------------------------------------------
// Run length memory
// One recorded run length per block, registered read, swept clear after reset.
// ----------------------------------------------------------------------------
module bffa_len_ram (
    input  logic                      i_clk,
    input  bffa_pkg::t_len_req        i_req,
    output logic [bffa_pkg::CntW-1:0] o_rdata
);
    logic [bffa_pkg::CntW-1:0] r_mem [bffa_pkg::NumBlocks];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            o_rdata <= r_mem[i_req.addr];
        end
    end
endmodule

// ===== verif/bffa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator checker
// Watches the register write, request and result channels. It keeps its own
// bitmap, run length table and used count, works out the result of each
// accepted request and compares it with the strobed result, field by field.
// ----------------------------------------------------------------------------
module bffa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_opcode,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_free_address,
    input  logic        i_valid,
    input  logic [31:0] i_result_address,
    input  logic [3:0]  i_status,
    input  logic [11:0] i_used_blocks,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0]       addr;
        bffa_pkg::t_status status;
        logic [11:0]       used;
    } t_alloc_result;

    localparam logic OP_ALLOC = 1'b0;

    logic [31:0]               kernel_end;
    bit                        block_busy [bffa_pkg::NumBlocks];
    logic [bffa_pkg::CntW-1:0] run_len [bffa_pkg::NumBlocks];
    int unsigned               used_count;
    t_alloc_result             expected_q [$];
    int                        fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic logic [31:0] heap_base();
        longint unsigned r;
        r = ((longint'(kernel_end) + bffa_pkg::BlockBytes - 1) / bffa_pkg::BlockBytes)
            * bffa_pkg::BlockBytes;
        return r[31:0];
    endfunction

    function automatic t_alloc_result grant(logic [31:0] bytes);
        t_alloc_result   res;
        longint unsigned blocks;
        longint unsigned a;
        int              run;
        int              first;
        res = '{addr: 32'd0, status: bffa_pkg::ST_ZERO, used: 12'd0};
        first = -1;
        run = 0;
        if (bytes != 0) begin
            blocks = (longint'(bytes) + bffa_pkg::HeaderBytes + bffa_pkg::BlockBytes - 1)
                     / bffa_pkg::BlockBytes;
            if (blocks > bffa_pkg::NumBlocks) begin
                res.status = bffa_pkg::ST_TOO_LARGE;
            end else begin
                for (int k = 0; k < bffa_pkg::NumBlocks && first < 0; k++) begin
                    if (block_busy[k]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == blocks) first = k + 1 - run;
                    end
                end
                if (first < 0) begin
                    res.status = bffa_pkg::ST_NO_ROOM;
                end else begin
                    for (int k = 0; k < blocks; k++) block_busy[first + k] = 1'b1;
                    run_len[first] = bffa_pkg::CntW'(blocks);
                    used_count += int'(blocks);
                    a = longint'(heap_base()) + longint'(first) * bffa_pkg::BlockBytes
                        + bffa_pkg::HeaderBytes;
                    res.addr   = a[31:0];
                    res.status = bffa_pkg::ST_ALLOC_OK;
                end
            end
        end
        res.used = used_count[11:0];
        return res;
    endfunction

    function automatic t_alloc_result release_run(logic [31:0] addr);
        t_alloc_result   res;
        logic [31:0]     hdr;
        logic [31:0]     base;
        longint unsigned idx;
        int unsigned     len;
        res  = '{addr: 32'd0, status: bffa_pkg::ST_NULL, used: 12'd0};
        hdr  = addr - bffa_pkg::HeaderBytes;
        base = heap_base();
        if (addr != 0) begin
            idx = longint'(hdr - base) / bffa_pkg::BlockBytes;
            if (hdr < base) begin
                res.status = bffa_pkg::ST_BEFORE;
            end else if (idx >= bffa_pkg::NumBlocks) begin
                res.status = bffa_pkg::ST_BEYOND;
            end else begin
                len = run_len[idx];
                if (len == 0 || len > bffa_pkg::NumBlocks) begin
                    res.status = bffa_pkg::ST_BAD_COUNT;
                end else begin
                    // Clearing stops at the end of the heap.
                    for (int k = 0; k < len && k + idx < bffa_pkg::NumBlocks; k++)
                        block_busy[idx + k] = 1'b0;
                    used_count = (used_count > len) ? used_count - len : 0;
                    res.status = bffa_pkg::ST_FREE_OK;
                end
            end
        end
        res.used = used_count[11:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            kernel_end = 32'd0;
            used_count = 0;
            foreach (block_busy[k]) begin
                block_busy[k] = 1'b0;
                run_len[k]    = '0;
            end
            expected_q.delete();
        end else begin
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding: address %h status %0d",
                           i_result_address, i_status);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_result_address !== want.addr) begin
                        $error("result_address: expected %h, got %h",
                               want.addr, i_result_address);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_used_blocks !== want.used) begin
                        $error("used_blocks: expected %0d, got %0d",
                               want.used, i_used_blocks);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) kernel_end = i_cfg_data;
            if (i_start && !i_busy) begin
                if (i_opcode == OP_ALLOC) expected_q.push_back(grant(i_request_bytes));
                else expected_q.push_back(release_run(i_free_address));
            end
        end
    end

    initial fails = 0;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator testbench
// Drives allocate and free requests over several heap base settings, with a
// directed opening for the error cases and a random tail of mostly valid
// allocate and free traffic. The checker module judges every result.
// ----------------------------------------------------------------------------
module tb;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        i_opcode;
    logic [31:0] i_request_bytes;
    logic [31:0] i_free_address;
    logic        o_valid;
    logic [31:0] o_result_address;
    logic [3:0]  o_status;
    logic [11:0] o_used_blocks;
    int          fail_count;
    int          pending;

    logic [31:0] live_q [$];
    logic [31:0] freed_q [$];
    int          n_sent;
    int          n_done;
    int          n_granted;
    int          n_settings;

    bitmap_first_fit_block_allocator u_dut (.*);

    bffa_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_opcode, .i_request_bytes, .i_free_address,
        .i_valid(o_valid), .i_result_address(o_result_address),
        .i_status(o_status), .i_used_blocks(o_used_blocks),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Granted addresses feed later free requests.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_done++;
            if (o_status == bffa_pkg::ST_ALLOC_OK) begin
                live_q.push_back(o_result_address);
                n_granted++;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called at a falling edge; returns at a falling edge after acceptance and a random gap.
    // Busy only changes at a rising edge, so a low busy seen here means the
    // next rising edge takes the request.
    task automatic issue(logic op, logic [31:0] bytes, logic [31:0] addr);
        int g;
        while (busy) @(negedge i_clk);
        i_opcode        <= op;
        i_request_bytes <= bytes;
        i_free_address  <= addr;
        start           <= 1'b1;
        @(negedge i_clk);
        n_sent++;
        g = gap_len();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (n_done != n_sent || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_kernel_end(logic [31:0] value);
        drain();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        live_q.delete();
        freed_q.delete();
        n_settings++;
    endtask

    task automatic free_live();
        int k;
        logic [31:0] a;
        k = $urandom_range(0, live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
        freed_q.push_back(a);
        issue(OP_FREE, 32'd0, a);
    endtask

    task automatic random_traffic(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                issue(OP_ALLOC, $urandom_range(1, 3 * bffa_pkg::BlockBytes), $urandom);
            end else if (r < 50) begin
                issue(OP_ALLOC, $urandom_range(1, 300 * bffa_pkg::BlockBytes), $urandom);
            end else if (r < 53) begin
                issue(OP_ALLOC, $urandom, $urandom);
            end else if (r < 88 && live_q.size() > 0) begin
                free_live();
            end else if (r < 91 && freed_q.size() > 0) begin
                // Freeing again clears the same run a second time.
                issue(OP_FREE, $urandom, freed_q[$urandom_range(0, freed_q.size() - 1)]);
            end else if (r < 96) begin
                issue(OP_FREE, $urandom, $urandom);
            end else begin
                issue(OP_FREE, $urandom, $urandom_range(0, 3));
            end
        end
    endtask

    initial begin
        logic [31:0] base;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 32'd0;
        i_opcode        = OP_ALLOC;
        i_request_bytes = 32'd0;
        i_free_address  = 32'd0;
        n_sent = 0; n_done = 0; n_granted = 0; n_settings = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening with a base that leaves room below the heap.
        set_kernel_end(32'h0001_2345);
        base = 32'h0001_3000;
        issue(OP_ALLOC, 32'd0, 32'd0);
        issue(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
        issue(OP_ALLOC, bffa_pkg::NumBlocks * bffa_pkg::BlockBytes - 3, 32'd0);
        issue(OP_ALLOC, bffa_pkg::NumBlocks * bffa_pkg::BlockBytes - 4, 32'd0);
        issue(OP_ALLOC, 32'd1, 32'd0);
        issue(OP_FREE, 32'd0, base + 4);
        issue(OP_FREE, 32'd0, base + 4);
        issue(OP_FREE, 32'd0, 32'd0);
        issue(OP_FREE, 32'd0, 32'd1);
        issue(OP_FREE, 32'd0, 32'd3);
        issue(OP_FREE, 32'd0, 32'd4);
        issue(OP_FREE, 32'd0, base + 3);
        issue(OP_FREE, 32'd0, base + bffa_pkg::NumBlocks * bffa_pkg::BlockBytes + 4);
        issue(OP_FREE, 32'd0, base + 5 * bffa_pkg::BlockBytes + 4);
        issue(OP_ALLOC, 32'd1, 32'd0);
        issue(OP_ALLOC, bffa_pkg::BlockBytes - 4, 32'd0);
        issue(OP_ALLOC, bffa_pkg::BlockBytes - 3, 32'd0);
        issue(OP_FREE, 32'd0, base + bffa_pkg::BlockBytes + 4);
        issue(OP_ALLOC, 2 * bffa_pkg::BlockBytes, 32'd0);
        issue(OP_FREE, 32'd0, base + 4);
        issue(OP_FREE, 32'd0, base + 4);
        issue(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_traffic(110);

        set_kernel_end(32'd0);
        random_traffic(120);
        set_kernel_end(32'hFFFF_FFFF);
        random_traffic(120);
        set_kernel_end(32'hFFFF_8001);
        random_traffic(110);
        set_kernel_end($urandom);
        random_traffic(110);
        set_kernel_end(32'd1);
        random_traffic(110);

        drain();
        repeat (300) @(negedge i_clk);
        $display("Ran %0d requests over %0d heap base settings, %0d allocations granted.",
                 n_sent, n_settings, n_granted);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing.", fail_count, pending);
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("Timed out waiting for the allocator.");
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bffa_pkg.sv
src/bffa_map_ram.sv
src/bffa_len_ram.sv
src/bitmap_first_fit_block_allocator.sv
verif/bffa_checker.sv
verif/tb.sv
